// ===== sv/gbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbf_pkg;

  // Frame store geometry
  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W      = 9;
  localparam int PAGE_ROWS   = 8;
  localparam logic [7:0] FULL_BYTE = 8'hFF;

  // Operation codes carried on func
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_PLOT  = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLOT_RD,
    S_PLOT_WR,
    S_READ,
    S_FINISH
  } state_t;

  // Result of mapping one pixel onto the frame store
  typedef struct packed {
    logic              inb;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } pix_map_t;

endpackage

`default_nettype wire

// ===== sv/glyph_blit_page_framebuffer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Monochrome page framebuffer: a 512-byte store with one write and one
// registered read port, 8 pixels tall per byte, driven by a small sequencer.
// One request is worked at a time. After reset the whole store is swept to
// zero, one byte a cycle, before the first request is taken. A clear request
// runs the same sweep over all 512 bytes, filling with 0xFF when its pattern
// is nonzero and with zero otherwise. A plot reads and then writes back the
// byte of each set, on-screen pixel among the first bit_count bits of its
// pattern, with bit_count capped at 8. The result is loaded into the output
// register as the sequencer returns to idle. A new request is taken as soon
// as the previous result is staged, even while that result still waits on
// out_ready.
module glyph_blit_page_framebuffer_top import gbf_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        func,
  input  wire logic signed [8:0] pos_x,
  input  wire logic signed [8:0] pos_y,
  input  wire logic [7:0]        pattern,
  input  wire logic [3:0]        bit_count,
  input  wire logic [8:0]        byte_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             read_data,
  output logic                   clipped
);

  localparam int FB_RAW      = SCREEN_WIDTH * SCREEN_HEIGHT / PAGE_ROWS;
  localparam int FRAME_BYTES = (FB_RAW < STORE_DEPTH) ? FB_RAW : STORE_DEPTH;

  state_t state;
  state_t state_next;

  logic [7:0]        mem [STORE_DEPTH];
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_wa;
  logic [ADDR_W-1:0] mem_ra;
  logic [7:0]        mem_wd;
  logic [7:0]        mem_rd;

  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        fill;
  logic              init_pass;
  logic [3:0]        k;
  logic [3:0]        cnt;
  logic [7:0]        pat;
  logic signed [8:0] px;
  logic signed [8:0] py;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_mask;
  logic              rd_ok;
  logic [7:0]        res_data;
  logic              res_clip;
  logic              out_load;
  logic              in_fire;
  logic              addr_ok;
  logic              pix_on;
  logic signed [9:0] pix_x;
  pix_map_t          pmap;

  assign in_fire = in_valid && in_ready;
  assign addr_ok = {1'b0, byte_index} < 10'(FRAME_BYTES);
  assign pix_x   = {px[8], px} + {6'd0, k};
  assign pix_on  = pat[3'd7 - k[2:0]];

  gbf_pixel_map #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_map (
    .x   (pix_x),
    .y   (py),
    .map (pmap)
  );

  // Frame store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd <= mem[mem_ra];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = clr_addr;
    mem_wd     = fill;
    mem_ra     = byte_index;
    out_load   = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = init_pass ? S_IDLE : S_FINISH;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (func_t'(func))
            FUNC_CLEAR: state_next = S_CLEAR;
            FUNC_PLOT:  state_next = S_PLOT_RD;
            FUNC_LOAD: begin
              mem_we     = addr_ok;
              mem_wa     = byte_index;
              mem_wd     = pattern;
              state_next = S_FINISH;
            end
            FUNC_READ: begin
              mem_re     = 1'b1;
              state_next = S_READ;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_PLOT_RD: begin
        if (k >= cnt) begin
          state_next = S_FINISH;
        end else if (pix_on && pmap.inb) begin
          mem_re     = 1'b1;
          mem_ra     = pmap.addr;
          state_next = S_PLOT_WR;
        end
      end
      S_PLOT_WR: begin
        mem_we     = 1'b1;
        mem_wa     = wr_addr;
        mem_wd     = mem_rd | wr_mask;
        state_next = S_PLOT_RD;
      end
      S_READ: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sweep control: reset starts a zero fill; a clear request sets the fill byte
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      fill      <= '0;
      init_pass <= 1'b1;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          init_pass <= 1'b0;
        end
      end
      if (in_fire && func_t'(func) == FUNC_CLEAR) begin
        fill <= (pattern != 8'd0) ? FULL_BYTE : 8'h00;
      end
    end
  end

  // Request capture, pixel walk and result staging
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pat      <= pattern;
      px       <= pos_x;
      py       <= pos_y;
      cnt      <= (bit_count > 4'(PAGE_ROWS)) ? 4'(PAGE_ROWS) : bit_count;
      k        <= '0;
      rd_ok    <= addr_ok;
      res_data <= '0;
      res_clip <= 1'b0;
    end
    if (state == S_PLOT_RD && k < cnt) begin
      k <= k + 1'b1;
      if (pix_on) begin
        if (pmap.inb) begin
          wr_addr <= pmap.addr;
          wr_mask <= pmap.mask;
        end else begin
          res_clip <= 1'b1;
        end
      end
    end
    if (state == S_READ) begin
      res_data <= rd_ok ? mem_rd : 8'h00;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data <= res_data;
      clipped   <= res_clip;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gbf_pixel_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbf_pixel_map import gbf_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic signed [9:0] x,
  input  wire logic signed [8:0] y,
  output pix_map_t               map
);

  logic [8:0]  x_u;
  logic [7:0]  y_u;
  logic        x_ok;
  logic        y_ok;
  logic [15:0] idx;

  // Bounds check on both axes, then page-ordered byte address
  always_comb begin
    x_u  = x[8:0];
    y_u  = y[7:0];
    x_ok = !x[9] && ({1'b0, x_u} < 10'(SCREEN_WIDTH));
    y_ok = !y[8] && ({1'b0, y_u} < 9'(SCREEN_HEIGHT));
    idx  = 16'(x_u) + 16'(y_u[7:3]) * 16'(SCREEN_WIDTH);
    map.inb  = x_ok && y_ok && (idx < 16'(STORE_DEPTH));
    map.addr = idx[ADDR_W-1:0];
    map.mask = 8'(1) << y_u[2:0];
  end

endmodule

`default_nettype wire

// ===== sv/gbf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbf_checker import gbf_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] func,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data,
  input wire logic       clipped
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(clipped))
    else $error("result changed while stalled");

  // Reset starts the clearing sweep, so no request is taken right after it
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken during reset sweep");

  // A clip flag only comes from plot, which returns no data
  a_clip_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> read_data == 8'h00)
    else $error("clipped result carries data");

  // A clear request occupies the store for its sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_CLEAR |=> !in_ready)
    else $error("request taken at start of clear");

endmodule

bind glyph_blit_page_framebuffer_top gbf_checker u_gbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .func      (func),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .read_data (read_data),
  .clipped   (clipped)
);

`default_nettype wire
